/* rtl/tkts_pkg.sv */
// shared constants and types of the top-k token sampler
package tkts_pkg;

  // sizes of the candidate chain and of the vocabulary
  localparam int MAX_KEEP   = 64;
  localparam int MAX_VOCAB  = 16384;

  // field widths
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 14;
  localparam int RND_W      = 31;
  localparam int KEEP_CFG_W = 7;

  // derived widths
  localparam int CNT_W      = $clog2(MAX_VOCAB + 1);
  localparam int RANK_W     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KSAT_W     = $clog2(MAX_KEEP + 1);
  localparam int K_W        = (KSAT_W > KEEP_CFG_W) ? KSAT_W : KEEP_CFG_W;
  localparam int CMP_W      = (CNT_W > K_W) ? CNT_W : K_W;
  localparam int MOD_CNT_W  = $clog2(RND_W);

  // configuration port
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam logic REG_KEEP   = 1'b0;
  localparam logic REG_SAMPLE = 1'b1;
  localparam logic [KEEP_CFG_W-1:0] KEEP_RESET = KEEP_CFG_W'(40);
  localparam logic SAMPLE_RESET = 1'b1;

  // one candidate: logit, token index and occupied flag
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
  } entry_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctl_t;

endpackage

/* rtl/tkts_cell.sv */
// one cell of the sorted candidate chain
module tkts_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tkts_pkg::cell_ctl_t ctl_i,
  input  tkts_pkg::entry_t   pass_i,
  input  tkts_pkg::entry_t   up_i,
  output tkts_pkg::entry_t   stored_o,
  output tkts_pkg::entry_t   pass_o
);

  tkts_pkg::entry_t st_r, st_nxt;
  tkts_pkg::entry_t pass_r, pass_nxt;
  logic             wins;

  // incoming candidate outranks the held one: larger logit, or equal logit and lower index
  assign wins = pass_i.vld &&
                (!st_r.vld ||
                 ($signed(pass_i.val) > $signed(st_r.val)) ||
                 ((pass_i.val == st_r.val) && (pass_i.idx < st_r.idx)));

  // insert, shift towards the head, or clear
  always_comb begin
    st_nxt   = st_r;
    pass_nxt = pass_r;
    if (ctl_i.clr) begin
      st_nxt.vld   = 1'b0;
      pass_nxt.vld = 1'b0;
    end else if (ctl_i.shift) begin
      st_nxt       = up_i;
      pass_nxt.vld = 1'b0;
    end else if (ctl_i.ins) begin
      if (wins) begin
        st_nxt   = pass_i;
        pass_nxt = st_r;
      end else begin
        pass_nxt = pass_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld   <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign stored_o = st_r;
  assign pass_o   = pass_r;

endmodule

/* rtl/tkts_mod.sv */
// bit-serial remainder of the random value by the candidate count
module tkts_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [tkts_pkg::RND_W-1:0]    dividend_i,
  input  logic [tkts_pkg::K_W-1:0]      divisor_i,
  output logic                          done_o,
  output logic [tkts_pkg::K_W-1:0]      rem_o
);

  logic                             busy_r, busy_nxt;
  logic [tkts_pkg::MOD_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [tkts_pkg::RND_W-1:0]       dvd_r, dvd_nxt;
  logic [tkts_pkg::K_W-1:0]         dvs_r, dvs_nxt;
  logic [tkts_pkg::K_W-1:0]         rem_r, rem_nxt;
  logic [tkts_pkg::K_W:0]           rem_sh;

  // one restoring step per cycle, most significant bit first
  assign rem_sh = {rem_r, dvd_r[tkts_pkg::RND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend_i;
      dvs_nxt  = divisor_i;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[tkts_pkg::RND_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = tkts_pkg::K_W'(rem_sh - {1'b0, dvs_r});
      end else begin
        rem_nxt = tkts_pkg::K_W'(rem_sh);
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tkts_pkg::MOD_CNT_W'(tkts_pkg::RND_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done_o = !busy_r;
  assign rem_o  = rem_r;

endmodule

/* rtl/top_k_token_sampler_core.sv */
// top level of the top-k token sampler: stream ports, register port, control
//
// Usage
//   The in_ channel takes one logit per request in token index order; tlast
//   marks the final logit of a vocabulary. Logits stream in at one per cycle
//   while in_tready is high. Each logit enters a chain of MAX_KEEP cells that
//   holds the best candidates in descending order, ties ranked by lower token
//   index. After the last logit, in_tready falls while the chain drains (the
//   bit-serial remainder unit runs alongside), then the chain shifts towards
//   its head once per rank step. The state then moves to ST_OUT, which
//   registers the head's token index onto out_tdata once the out_ slot is
//   free; the chain clears in the same cycle and in_tready rises again.
//   The out_ channel has its own register: a stalled receiver does not hold up
//   the next vocabulary until its result is ready; it then waits for the slot.
//   keep_count (address 0) and sample_enable (address 4) are written through
//   the cfg_ port while the block is idle; the user must see to it, not the block.
//   Reset empties the chain, zeroes the logit count and loads keep_count 40
//   and sample_enable 1; no clearing pass is needed.
module top_k_token_sampler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // logit_value[31:0], random_value[62:32]
  input  logic                          in_tlast,   // last_item
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // token_index[13:0]
  // register port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tkts_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [tkts_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [tkts_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]                         state_r, state_nxt;
  logic [tkts_pkg::KEEP_CFG_W-1:0]    keep_r, keep_nxt;
  logic                               sample_r, sample_nxt;
  logic [tkts_pkg::CNT_W-1:0]         seen_r, seen_nxt;
  logic [tkts_pkg::RANK_W-1:0]        drain_r, drain_nxt;
  logic [tkts_pkg::RANK_W-1:0]        rank_r, rank_nxt;
  logic                               out_vld_r, out_vld_nxt;
  logic [tkts_pkg::IDX_W-1:0]         out_idx_r, out_idx_nxt;

  logic                               in_acc;
  logic                               cfg_wr;
  logic                               room;
  logic                               drain_done;
  logic                               out_load;
  logic                               greedy;
  logic [tkts_pkg::K_W-1:0]           k_sat;
  logic                               mod_done;
  logic [tkts_pkg::K_W-1:0]           mod_rem;
  tkts_pkg::entry_t                   new_ent;
  tkts_pkg::cell_ctl_t                ctl;
  tkts_pkg::entry_t                   st_q   [tkts_pkg::MAX_KEEP];
  tkts_pkg::entry_t                   pass_q [tkts_pkg::MAX_KEEP];
  logic [tkts_pkg::MAX_KEEP-1:0]      pass_vld;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_RUN);
  assign room       = (seen_r < tkts_pkg::CNT_W'(tkts_pkg::MAX_VOCAB));
  assign drain_done = (drain_r == tkts_pkg::RANK_W'(tkts_pkg::MAX_KEEP - 1));
  assign out_load   = (state_r == ST_OUT) && (!out_vld_r || out_tready);

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tkts_pkg::REG_SAMPLE) ?
                      tkts_pkg::DATA_W'(sample_r) : tkts_pkg::DATA_W'(keep_r);

  always_comb begin
    keep_nxt   = keep_r;
    sample_nxt = sample_r;
    if (cfg_wr) begin
      if (cfg_paddr[2] == tkts_pkg::REG_KEEP) begin
        keep_nxt = cfg_pwdata[tkts_pkg::KEEP_CFG_W-1:0];
      end else begin
        sample_nxt = cfg_pwdata[0];
      end
    end
  end

  // keep count saturated to the chain length
  assign k_sat = (tkts_pkg::K_W'(keep_r) > tkts_pkg::K_W'(tkts_pkg::MAX_KEEP)) ?
                 tkts_pkg::K_W'(tkts_pkg::MAX_KEEP) : tkts_pkg::K_W'(keep_r);

  assign greedy = !sample_r || (k_sat == '0) ||
                  (tkts_pkg::CMP_W'(k_sat) >= tkts_pkg::CMP_W'(seen_r));

  // new candidate entering the head of the chain
  always_comb begin
    new_ent.vld = in_acc && room;
    new_ent.idx = seen_r[tkts_pkg::IDX_W-1:0];
    new_ent.val = in_tdata[tkts_pkg::VAL_W-1:0];
  end

  // chain command
  always_comb begin
    ctl.ins   = (state_r == ST_RUN) || (state_r == ST_DRAIN);
    ctl.shift = (state_r == ST_SHIFT) && (rank_r != '0);
    ctl.clr   = out_load;
  end

  // sequencing of drain, rank shift and result
  always_comb begin
    state_nxt   = state_r;
    seen_nxt    = seen_r;
    drain_nxt   = drain_r;
    rank_nxt    = rank_r;
    out_vld_nxt = out_vld_r;
    out_idx_nxt = out_idx_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      ST_RUN: begin
        if (in_acc) begin
          if (room) begin
            seen_nxt = seen_r + 1'b1;
          end
          if (in_tlast) begin
            drain_nxt = '0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!drain_done) begin
          drain_nxt = drain_r + 1'b1;
        end else if (mod_done) begin
          rank_nxt  = greedy ? '0 : mod_rem[tkts_pkg::RANK_W-1:0];
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (rank_r != '0) begin
          rank_nxt = rank_r - 1'b1;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          out_idx_nxt = st_q[0].vld ? st_q[0].idx : '0;
          seen_nxt    = '0;
          state_nxt   = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      keep_r    <= tkts_pkg::KEEP_RESET;
      sample_r  <= tkts_pkg::SAMPLE_RESET;
      seen_r    <= '0;
      drain_r   <= '0;
      rank_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      keep_r    <= keep_nxt;
      sample_r  <= sample_nxt;
      seen_r    <= seen_nxt;
      drain_r   <= drain_nxt;
      rank_r    <= rank_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_idx_r <= out_idx_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = 16'(out_idx_r);

  // rank = random value mod k (zero in greedy mode), computed while the chain drains
  tkts_mod u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (in_acc && in_tlast),
    .dividend_i (in_tdata[62:32]),
    .divisor_i  (k_sat),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // candidate chain
  for (genvar i = 0; i < tkts_pkg::MAX_KEEP; i++) begin : g_cell
    tkts_pkg::entry_t pin;
    tkts_pkg::entry_t uin;
    if (i == 0) begin : g_head
      assign pin = new_ent;
    end else begin : g_body
      assign pin = pass_q[i-1];
    end
    if (i == tkts_pkg::MAX_KEEP - 1) begin : g_tail
      assign uin = '0;
    end else begin : g_mid
      assign uin = st_q[i+1];
    end
    tkts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (ctl),
      .pass_i   (pin),
      .up_i     (uin),
      .stored_o (st_q[i]),
      .pass_o   (pass_q[i])
    );
    assign pass_vld[i] = pass_q[i].vld;
  end

`ifndef NO_ASSERTIONS
  // no displaced candidate may still be moving when the drain ends;
  // the tail cell may still hold the candidate that falls off the chain
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && drain_done) |-> (pass_vld[tkts_pkg::MAX_KEEP-2:0] == '0))
    else $error("candidate still in flight at end of drain");

  // a non-empty vocabulary always leaves a candidate at the head
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && seen_r != '0) |-> st_q[0].vld)
    else $error("head of chain empty at result");

  // logit count is cleared after each result
  a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (seen_r == '0))
    else $error("logit count not cleared after result");

  // logit count never passes the vocabulary limit
  a_seen_max: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= tkts_pkg::CNT_W'(tkts_pkg::MAX_VOCAB))
    else $error("logit count beyond vocabulary limit");
`endif

endmodule

/* tb/sv/tb_top_k_token_sampler_core.sv */
// testbench for the top-k token sampler core: directed and random vocabularies
`timescale 1ns / 1ps

module tb_top_k_token_sampler_core;

  localparam logic [tkts_pkg::ADDR_W-1:0] KEEP_ADDR   = {tkts_pkg::REG_KEEP, 2'b00};
  localparam logic [tkts_pkg::ADDR_W-1:0] SAMPLE_ADDR = {tkts_pkg::REG_SAMPLE, 2'b00};
  localparam int DRAIN_CYCLES = 2 * tkts_pkg::MAX_KEEP + 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;   // logit_value[31:0], random_value[62:32]
  logic in_tlast = 1'b0;        // last_item
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;       // token_index[13:0]
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [tkts_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [tkts_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [tkts_pkg::DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  top_k_token_sampler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow registers and candidate list of the predictor
  logic [tkts_pkg::KEEP_CFG_W-1:0] keep_shadow = tkts_pkg::KEEP_RESET;
  logic sample_shadow = tkts_pkg::SAMPLE_RESET;
  logic signed [tkts_pkg::VAL_W-1:0] top_val [tkts_pkg::MAX_KEEP];
  logic [tkts_pkg::IDX_W-1:0] top_idx [tkts_pkg::MAX_KEEP];
  bit top_used [tkts_pkg::MAX_KEEP];
  int unsigned logits_in_vocab = 0;

  logic [tkts_pkg::IDX_W-1:0] expected_tokens [$];

  int unsigned error_count = 0;
  int unsigned logits_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned config_writes = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // clear the candidate list for the next vocabulary
  function automatic void clear_candidates();
    for (int i = 0; i < tkts_pkg::MAX_KEEP; i++) begin
      top_val[i] = '0;
      top_idx[i] = '0;
      top_used[i] = 1'b0;
    end
    logits_in_vocab = 0;
  endfunction

  // insert one logit behind every entry that is larger or equal
  function automatic void insert_candidate(logic signed [tkts_pkg::VAL_W-1:0] val,
                                           int unsigned idx);
    int pos;
    pos = 0;
    while (pos < tkts_pkg::MAX_KEEP && top_used[pos] && top_val[pos] >= val) pos++;
    if (pos < tkts_pkg::MAX_KEEP) begin
      for (int i = tkts_pkg::MAX_KEEP - 1; i > pos; i--) begin
        top_val[i] = top_val[i-1];
        top_idx[i] = top_idx[i-1];
        top_used[i] = top_used[i-1];
      end
      top_val[pos] = val;
      top_idx[pos] = tkts_pkg::IDX_W'(idx);
      top_used[pos] = 1'b1;
    end
  endfunction

  // take one accepted logit; on the last one queue the chosen token
  function automatic void predict_token(logic [tkts_pkg::VAL_W-1:0] val, logic last,
                                        logic [tkts_pkg::RND_W-1:0] rnd);
    int unsigned k;
    int unsigned rank;
    logic [tkts_pkg::IDX_W-1:0] tok;
    if (logits_in_vocab < tkts_pkg::MAX_VOCAB) begin
      insert_candidate(val, logits_in_vocab);
      logits_in_vocab++;
    end
    if (last) begin
      k = (keep_shadow > tkts_pkg::MAX_KEEP) ? tkts_pkg::MAX_KEEP : keep_shadow;
      if (!sample_shadow || k == 0 || k >= logits_in_vocab) rank = 0;
      else rank = int'(rnd) % k;
      tok = (rank < tkts_pkg::MAX_KEEP && top_used[rank]) ? top_idx[rank] : '0;
      expected_tokens.push_back(tok);
      clear_candidates();
    end
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each returned token with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got token %0d",
                 $time, out_tdata);
        error_count++;
      end else begin
        if (out_tdata !== {{(16-tkts_pkg::IDX_W){1'b0}}, expected_tokens[0]}) begin
          $display("%0t ns: token_index mismatch, expected %0d, got %0d",
                   $time, expected_tokens[0], out_tdata);
          error_count++;
        end
        void'(expected_tokens.pop_front());
        tokens_checked++;
      end
    end
  end

  // one register request: setup cycle then access cycle
  task automatic cfg_access(input logic wr, input logic [tkts_pkg::ADDR_W-1:0] addr,
                            input logic [tkts_pkg::DATA_W-1:0] wdata,
                            output logic [tkts_pkg::DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // read one register and compare with its shadow
  task automatic check_register(input logic [tkts_pkg::ADDR_W-1:0] addr,
                                input logic [tkts_pkg::DATA_W-1:0] want);
    logic [tkts_pkg::DATA_W-1:0] rdata;
    cfg_access(1'b0, addr, '0, rdata);
    if (rdata !== want) begin
      $display("%0t ns: register read mismatch at address %0d, expected %0d, got %0d",
               $time, addr, want, rdata);
      error_count++;
    end
  endtask

  // write both registers, then read them back
  task automatic set_config(input int unsigned keep, input bit sample);
    logic [tkts_pkg::DATA_W-1:0] rdata;
    cfg_access(1'b1, KEEP_ADDR, tkts_pkg::DATA_W'(keep), rdata);
    keep_shadow = tkts_pkg::KEEP_CFG_W'(keep);
    cfg_access(1'b1, SAMPLE_ADDR, tkts_pkg::DATA_W'(sample), rdata);
    sample_shadow = sample;
    config_writes += 2;
    check_register(KEEP_ADDR, tkts_pkg::DATA_W'(keep_shadow));
    check_register(SAMPLE_ADDR, tkts_pkg::DATA_W'(sample_shadow));
  endtask

  // send one logit request, with a random gap in front of it
  task automatic send_logit(input logic [tkts_pkg::VAL_W-1:0] val, input logic last,
                            input logic [tkts_pkg::RND_W-1:0] rnd);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, rnd, val};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_token(val, last, rnd);
    logits_sent++;
  endtask

  // drop valid and wait until every predicted token has come back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [tkts_pkg::RND_W-1:0] random_rnd();
    return tkts_pkg::RND_W'($urandom);
  endfunction

  // register values after reset
  task automatic test_register_reset();
    check_register(KEEP_ADDR, tkts_pkg::DATA_W'(tkts_pkg::KEEP_RESET));
    check_register(SAMPLE_ADDR, tkts_pkg::DATA_W'(tkts_pkg::SAMPLE_RESET));
  endtask

  // extreme logits and random values, one-logit vocabulary
  task automatic test_field_extremes();
    send_logit(32'h7FFF_FFFF, 1'b0, '0);
    send_logit(32'h8000_0000, 1'b0, '1);
    send_logit(32'h0000_0000, 1'b0, '0);
    send_logit(32'hFFFF_FFFF, 1'b0, '1);
    send_logit(32'h0000_0001, 1'b1, '1);
    wait_idle();
    set_config(2, 1'b1);
    send_logit(32'h8000_0000, 1'b0, '0);
    send_logit(32'hFFFF_FFFF, 1'b0, '0);
    send_logit(32'h7FFF_FFFF, 1'b0, '0);
    send_logit(32'h7FFF_FFFE, 1'b1, '1);
    send_logit(32'h1234_5678, 1'b1, '0);
    wait_idle();
  endtask

  // equal logits rank the lower index first
  task automatic test_tie_order();
    set_config(4, 1'b1);
    for (int r = 1; r < 4; r++) begin
      for (int i = 0; i < 5; i++) send_logit(32'h0001_0000, i == 4, tkts_pkg::RND_W'(r));
    end
    wait_idle();
  endtask

  // sampling off, keep count zero, keep count equal to and one below the vocabulary size
  task automatic test_greedy_modes();
    set_config(8, 1'b0);
    for (int i = 0; i < 10; i++) send_logit($urandom, i == 9, random_rnd());
    wait_idle();
    set_config(0, 1'b1);
    for (int i = 0; i < 10; i++) send_logit($urandom, i == 9, random_rnd());
    wait_idle();
    set_config(5, 1'b1);
    for (int i = 0; i < 5; i++) send_logit($urandom, i == 4, tkts_pkg::RND_W'(3));
    for (int i = 0; i < 6; i++) send_logit($urandom, i == 5, tkts_pkg::RND_W'(4));
    wait_idle();
  endtask

  // keep counts beyond the chain length saturate; a keep count at the chain length picks the last rank
  task automatic test_saturated_keep();
    set_config(127, 1'b1);
    for (int i = 0; i < 66; i++) send_logit($urandom, i == 65, random_rnd());
    wait_idle();
    set_config(tkts_pkg::MAX_KEEP, 1'b1);
    for (int i = 0; i < 65; i++) begin
      send_logit($urandom, i == 64, tkts_pkg::RND_W'(tkts_pkg::MAX_KEEP - 1));
    end
    wait_idle();
  endtask

  // random register setting, extremes included
  task automatic random_config();
    int unsigned pick;
    int unsigned keep;
    pick = $urandom_range(9);
    case (pick)
      0: keep = 0;
      1: keep = 1;
      2: keep = tkts_pkg::MAX_KEEP;
      3: keep = $urandom_range(1) ? 127 : $urandom_range(127, tkts_pkg::MAX_KEEP + 1);
      default: keep = $urandom_range(tkts_pkg::MAX_KEEP - 1, 2);
    endcase
    set_config(keep, $urandom_range(99) < 80);
  endtask

  // random vocabularies under one idling pattern
  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned quota);
    int unsigned sent;
    int unsigned vocabs;
    int unsigned len;
    int unsigned style;
    int unsigned pick;
    logic [tkts_pkg::VAL_W-1:0] val;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    vocabs = 0;
    while (sent < quota) begin
      if (vocabs % 3 == 0) begin
        wait_idle();
        random_config();
      end
      pick = $urandom_range(99);
      if (pick < 10) len = $urandom_range(3, 1);
      else if (pick < 75) len = $urandom_range(40, 4);
      else len = $urandom_range(140, 41);
      style = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        case (style)
          2: val = tkts_pkg::VAL_W'(($urandom_range(8) - 4) <<< 16);
          3: begin
            pick = $urandom_range(3);
            val = (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h8000_0000 : $urandom;
          end
          default: val = $urandom;
        endcase
        send_logit(val, i == len - 1, random_rnd());
      end
      sent += len;
      vocabs++;
    end
    wait_idle();
  endtask

  initial begin
    clear_candidates();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_field_extremes();
    test_tie_order();
    test_greedy_modes();
    test_saturated_keep();
    test_random_phase(0, 0, 260);
    test_random_phase(60, 0, 260);
    test_random_phase(0, 60, 260);
    test_random_phase(16, 16, 260);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d logits, %0d tokens checked, %0d register writes",
             logits_sent, tokens_checked, config_writes);
    $display("greedy, sampled, tied and saturated vocabularies under four idling patterns");
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("top_k_token_sampler_core test passed");
    end else begin
      $display("top_k_token_sampler_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("top_k_token_sampler_core test failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/tkts_pkg.sv
rtl/tkts_cell.sv
rtl/tkts_mod.sv
rtl/top_k_token_sampler_core.sv
tb/sv/tb_top_k_token_sampler_core.sv
